/* src/rkst_pkg.sv */
// shared types, codes and constants for the render key sorted table
`default_nettype none

package rkst_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int MODE_W   = 2;
	localparam int HANDLE_W = 16;
	localparam int KEY_W    = 16;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 7;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    drawable;
		logic [KEY_W-1:0]    material;
		logic [KEY_W-1:0]    texture;
	} entry_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic flag_en;
		logic ins_en;
		logic rem_en;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* src/render_key_sorted_table.sv */
// top level of the render key sorted table: control, cell row and result register
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+--------------------------------------------
//  in      | to block  | in_valid / in_stall  | mode entry_handle drawable_key material_key
//          |           |                      | texture_key read_position
//  out     | from block| out_valid / out_stall| status out_handle out_drawable out_material
//          |           |                      | out_texture entry_total
//
// a word is taken in the idle state, then the compare state follows, where every cell
// compares its entry with the word, then the update state, where the row shifts by one place
// and the result word is registered; the input stays stalled until the update state
// completes, so a new word is taken only once the last one is through
// reset clears the fill count and the control state; slot contents are never cleared
// while the result register is full and stalled the update state waits, the cell
// flags hold and the input stays stalled
// a new word is taken while the previous result still waits at the output
`default_nettype none

module render_key_sorted_table
	import rkst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [HANDLE_W-1:0] entry_handle,
	input  wire logic [KEY_W-1:0]    drawable_key,
	input  wire logic [KEY_W-1:0]    material_key,
	input  wire logic [KEY_W-1:0]    texture_key,
	input  wire logic [POS_W-1:0]    read_position,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [HANDLE_W-1:0]      out_handle,
	output logic [KEY_W-1:0]         out_drawable,
	output logic [KEY_W-1:0]         out_material,
	output logic [KEY_W-1:0]         out_texture,
	output logic [TOTAL_W-1:0]       entry_total
);

	// count width holds the capacity itself, index width addresses a slot
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [MODE_W-1:0]   mode_q;
	entry_t              operand_q;
	logic [POS_W-1:0]    pos_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	entry_t              rd_q;
	logic [TOTAL_W-1:0]  total_q;

	cell_ctl_t           ctl;
	entry_t              cell_entry [CAPACITY];
	logic [CAPACITY-1:0] gt_v;
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY-1:0] hit_incl;

	logic                in_take;
	logic                commit;
	logic                zero_key;
	logic                full;
	logic                found;
	logic                ins_ok;
	logic                rem_ok;
	logic                rd_ok;
	logic [CMPW-1:0]     pos_w;
	logic [IW-1:0]       rd_idx;
	logic [STATUS_W-1:0] status_d;
	entry_t              rd_d;
	logic [CW-1:0]       count_d;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	// the update state completes only when the result register can take the word
	assign commit = (state_q == S_UPD) && (!out_valid_q || !out_stall);

	// decisions made from the captured operand, the fill count and the registered cell flags
	assign zero_key = (operand_q.drawable == '0) || (operand_q.material == '0) ||
		(operand_q.texture == '0);
	assign full     = (count_q == CW'(CAPACITY));
	assign found    = |hit_v;
	assign ins_ok   = (mode_q == MODE_INSERT) && !zero_key && !full;
	assign rem_ok   = (mode_q == MODE_REMOVE) && found;
	assign pos_w    = CMPW'(pos_q);
	assign rd_ok    = (mode_q == MODE_READ) && (pos_w < CMPW'(count_q));
	assign rd_idx   = pos_w[IW-1:0];

	assign ctl.flag_en = (state_q == S_CMP);
	assign ctl.ins_en  = commit && ins_ok;
	assign ctl.rem_en  = commit && rem_ok;

	always_comb begin
		status_d = ST_OK;
		rd_d     = '0;
		count_d  = count_q;
		case (mode_q)
			MODE_INSERT: begin
				if (zero_key) begin
					status_d = ST_ZERO_KEY;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			MODE_REMOVE: begin
				if (found) begin
					count_d = count_q - CW'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			MODE_READ: begin
				if (rd_ok) begin
					rd_d = cell_entry[rd_idx];
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				// unused mode leaves the table alone
				status_d = ST_OK;
			end
		endcase
	end

	// sequencer, fill count and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// captured operand and result word
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q             <= mode;
			operand_q.handle   <= entry_handle;
			operand_q.drawable <= drawable_key;
			operand_q.material <= material_key;
			operand_q.texture  <= texture_key;
			pos_q              <= read_position;
		end
		if (commit) begin
			status_q <= status_d;
			rd_q     <= rd_d;
			total_q  <= TOTAL_W'(count_d);
		end
	end

	// row of slots, each wired to its neighbours; the first takes the operand on its left
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;

		if (i == 0) begin : g_first
			assign left_e = operand_q;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_g = gt_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		rkst_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.operand    (operand_q),
			.count      (count_q),
			.left_entry (left_e),
			.left_gt    (left_g),
			.right_entry(right_e),
			.hit_incl   (hit_incl[i]),
			.entry      (cell_entry[i]),
			.gt         (gt_v[i]),
			.hit        (hit_v[i])
		);
	end

	// first matching handle: every slot at or after it pulls from the right
	rkst_prefix #(
		.N(CAPACITY)
	) u_prefix (
		.hit     (hit_v),
		.hit_incl(hit_incl)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_handle   = rd_q.handle;
	assign out_drawable = rd_q.drawable;
	assign out_material = rd_q.material;
	assign out_texture  = rd_q.texture;
	assign entry_total  = total_q;

	// fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// one operation moves the fill count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + CW'(1)) ||
			(count_q == $past(count_q) - CW'(1)))
		else $error("fill count jumped");

	// a stored entry never carries a partly zero key
	a_read_keys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_drawable == '0) |-> (out_material == '0) && (out_texture == '0))
		else $error("read returned a partly zero key");

	// an insert is only committed while there is room
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en |-> (count_q < CW'(CAPACITY)))
		else $error("insert committed into a full table");

endmodule

`default_nettype wire

/* src/rkst_cell.sv */
// one table slot: holds an entry, compares it and shifts with its neighbours
`default_nettype none

module rkst_cell
	import rkst_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic          clk,
	input  wire cell_ctl_t     ctl,
	input  wire entry_t        operand,
	input  wire logic [CW-1:0] count,
	input  wire entry_t        left_entry,
	input  wire logic          left_gt,
	input  wire entry_t        right_entry,
	input  wire logic          hit_incl,
	output entry_t             entry,
	output logic               gt,
	output logic               hit
);

	entry_t entry_q;
	logic   gt_q;
	logic   hit_q;
	logic   valid;
	logic   tail;

	assign valid = CW'(IDX) < count;
	assign tail  = CW'(IDX) == count;

	always_ff @(posedge clk) begin
		if (ctl.flag_en) begin
			gt_q  <= valid && ({entry_q.drawable, entry_q.material, entry_q.texture} >
				{operand.drawable, operand.material, operand.texture});
			hit_q <= valid && (entry_q.handle == operand.handle);
		end
		if (ctl.ins_en) begin
			// everything above the insert point moves up by one
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt_q || tail) begin
				entry_q <= operand;
			end
		end else if (ctl.rem_en && hit_incl) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign gt    = gt_q;
	assign hit   = hit_q;

endmodule

`default_nettype wire

/* src/rkst_prefix.sv */
// log-depth prefix or over the handle match flags of the cell row
`default_nettype none

module rkst_prefix
	import rkst_pkg::*;
#(
	parameter int N = CAPACITY_DEF
) (
	input  wire logic [N-1:0] hit,
	output logic [N-1:0]      hit_incl
);

	logic [N-1:0] acc;

	always_comb begin
		acc = hit;
		for (int s = 1; s < N; s = s * 2) begin
			acc = acc | (acc << s);
		end
	end

	assign hit_incl = acc;

endmodule

`default_nettype wire
